@@ rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and helpers for the ARGB8888 pixel expander
// Source format codes and the channel widening functions.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Source format codes (register value)
  typedef enum logic [3:0] {
    FMT_RGB565   = 4'd0,
    FMT_ARGB4444 = 4'd1,
    FMT_ARGB6666 = 4'd2,
    FMT_ARGB8565 = 4'd3,
    FMT_RGB888   = 4'd4,
    FMT_ARGB8888 = 4'd5,
    FMT_GRAY8    = 4'd6,
    FMT_GRAY4    = 4'd7,
    FMT_GRAY2    = 4'd8,
    FMT_MONO     = 4'd9,
    FMT_INDEXED  = 4'd10,
    FMT_UNKNOWN  = 4'd11
  } fmt_t;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [31:0] ARGB_WHITE   = 32'hFFFF_FFFF;
  localparam logic [31:0] ARGB_BLACK   = 32'hFF00_0000;

  // Expander result
  typedef struct packed {
    logic [31:0] argb_color;
    logic        format_supported;
  } pfa_result_t;

  // 4-bit to 8-bit: x * 17
  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  // 5-bit to 8-bit: high-bit replication
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // 6-bit to 8-bit: high-bit replication
  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // 2-bit to 8-bit: x * 85
  function automatic logic [7:0] widen2(input logic [1:0] v);
    return {v, v, v, v};
  endfunction

endpackage

@@ rtl/pixel_format_to_argb8888.sv @@
// ----------------------------------------------------------------------------
// pixel_format_to_argb8888: raw pixel to ARGB8888 expander
// Two-register pipeline: input register, conversion logic, result register.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid, in_ready, pixel_bytes, sub_pos. | in
//  out      | out_valid, out_ready, argb_color, f._sup. | out
//  cfg      | cfg_write_en, cfg_write_data              | in
//
// One word per clock sustained while out_ready stays high; an accepted word
// passes the input register and then the result register, which raises out_valid.
// Each register stage advances when empty or when the stage after it moves.
// Reset empties both stages and sets the source format to unknown.
// A stall at out holds the result; in_ready drops only with both stages full.
// ----------------------------------------------------------------------------
module pixel_format_to_argb8888 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pixel_bytes,
  input  logic [2:0]  sub_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] argb_color,
  output logic        format_supported,
  input  logic        cfg_write_en,
  input  logic [3:0]  cfg_write_data
);
  import pfa_pkg::*;

  fmt_t        source_format;
  logic        s1_valid;
  logic [31:0] s1_pixel;
  logic [2:0]  s1_pos;
  logic        s2_ready;
  pfa_result_t conv;

  // Format register
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_UNKNOWN;
    end else if (cfg_write_en) begin
      source_format <= fmt_t'(cfg_write_data);
    end
  end

  // Handshake between stages
  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_pixel <= pixel_bytes;
      s1_pos   <= sub_position;
    end
  end

  // Conversion
  pfa_expand u_expand (
    .fmt          (source_format),
    .pixel_bytes  (s1_pixel),
    .sub_position (s1_pos),
    .result       (conv)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && s2_ready) begin
      argb_color       <= conv.argb_color;
      format_supported <= conv.format_supported;
    end
  end

`ifndef SYNTHESIS
  // Input stalls only with both stages holding a word
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid))
    else $error("in_ready low with a free stage");

  // A word in stage 1 with room ahead reaches the result register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_ready) |=> out_valid)
    else $error("stage 1 word lost");

  // Unsupported formats give zero color
  a_unsup_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !format_supported) |-> (argb_color == 32'd0))
    else $error("unsupported format with nonzero color");

  // RGB565, RGB888, mono and gray8 results are opaque
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (source_format == FMT_RGB565 || source_format == FMT_RGB888 ||
                   source_format == FMT_MONO || source_format == FMT_GRAY8))
    |-> (argb_color[31:24] == ALPHA_OPAQUE))
    else $error("opaque format with alpha below full");
`endif

endmodule

@@ rtl/pfa_expand.sv @@
// ----------------------------------------------------------------------------
// pfa_expand: pixel to ARGB8888 conversion logic
// Combinational widening of one raw pixel under the selected source format.
// ----------------------------------------------------------------------------
module pfa_expand (
  input  pfa_pkg::fmt_t        fmt,
  input  logic [31:0]          pixel_bytes,
  input  logic [2:0]           sub_position,
  output pfa_pkg::pfa_result_t result
);
  import pfa_pkg::*;

  logic [7:0]  b0, b1, b2;
  logic [15:0] w565;
  logic [23:0] w6666;
  logic [3:0]  g4;
  logic [1:0]  g2;
  logic [7:0]  gval;
  logic        mono_bit;

  assign b0 = pixel_bytes[31:24];
  assign b1 = pixel_bytes[23:16];
  assign b2 = pixel_bytes[15:8];

  // 565 word: top half for RGB565, bytes 1-2 for ARGB8565
  assign w565  = (fmt == FMT_ARGB8565) ? {b1, b2} : pixel_bytes[31:16];
  assign w6666 = pixel_bytes[31:8];

  // Sub-byte sample picks, counted from the MSB end
  assign g4 = sub_position[0] ? b0[3:0] : b0[7:4];
  always_comb begin
    case (sub_position[1:0])
      2'd0:    g2 = b0[7:6];
      2'd1:    g2 = b0[5:4];
      2'd2:    g2 = b0[3:2];
      default: g2 = b0[1:0];
    endcase
  end
  assign mono_bit = b0[~sub_position];

  // Gray level for the gray formats
  always_comb begin
    case (fmt)
      FMT_GRAY4: gval = widen4(g4);
      FMT_GRAY2: gval = widen2(g2);
      default:   gval = b0;
    endcase
  end

  // Format decode
  always_comb begin
    result.format_supported = 1'b1;
    unique case (fmt)
      FMT_RGB565:
        result.argb_color = {ALPHA_OPAQUE, widen5(w565[15:11]), widen6(w565[10:5]),
                             widen5(w565[4:0])};
      FMT_ARGB8565:
        result.argb_color = {b0, widen5(w565[15:11]), widen6(w565[10:5]),
                             widen5(w565[4:0])};
      FMT_ARGB4444:
        result.argb_color = {widen4(b0[7:4]), widen4(b0[3:0]),
                             widen4(b1[7:4]), widen4(b1[3:0])};
      FMT_ARGB6666:
        result.argb_color = {widen6(w6666[23:18]), widen6(w6666[17:12]),
                             widen6(w6666[11:6]), widen6(w6666[5:0])};
      FMT_RGB888:
        result.argb_color = {ALPHA_OPAQUE, pixel_bytes[31:8]};
      FMT_ARGB8888:
        result.argb_color = pixel_bytes;
      FMT_GRAY8, FMT_GRAY4, FMT_GRAY2:
        result.argb_color = {ALPHA_OPAQUE, gval, gval, gval};
      FMT_MONO:
        result.argb_color = mono_bit ? ARGB_WHITE : ARGB_BLACK;
      default: begin
        // indexed, unknown and unused codes
        result.argb_color       = 32'd0;
        result.format_supported = 1'b0;
      end
    endcase
  end

endmodule
